[rtl/core/tbm_pkg.sv]
// tbm_pkg: shared types, constants and the type decoder for the terrain blend block
// used by tbm_lane, tbm_merge and terrain_blend_type_and_mask_top
// no dependencies
package tbm_pkg;

   // field widths and counts
   localparam int FIELD_BITS = 7;
   localparam int TYPE_BITS  = 6;
   localparam int NEIGHBOURS = 8;
   localparam int COUNT_BITS = 4;
   localparam int MASK_BITS  = 8;
   localparam int IDX_BITS   = 3;

   // number of valid material types; codes at or above it count as no-draw
   localparam int TYPE_COUNT = 64;

   // decoded material type: valid low means no-draw
   typedef struct packed {
      logic                 valid;
      logic [TYPE_BITS-1:0] value;
   } type_code_type;

   typedef type_code_type [NEIGHBOURS-1:0] nb_vec_type;

   // what one lane reports about its neighbour
   typedef struct packed {
      logic                  cand;
      logic [TYPE_BITS-1:0]  ty;
      logic [NEIGHBOURS-1:0] match;
      logic [COUNT_BITS-1:0] count;
   } lane_result_type;

   typedef lane_result_type [NEIGHBOURS-1:0] lane_vec_type;

   // merged outcome for one transaction
   typedef struct packed {
      logic                 skipped;
      logic [TYPE_BITS-1:0] blend_type;
      logic [MASK_BITS-1:0] mask;
   } merge_result_type;

   // mask bit of each neighbour, in scan order NW, N, NE, W, E, SW, S, SE
   localparam logic [IDX_BITS-1:0] SCAN_BIT [NEIGHBOURS] = '{
      3'd0, 3'd1, 3'd2, 3'd7, 3'd3, 3'd6, 3'd5, 3'd4
   };

   // negative codes and codes at or above TYPE_COUNT are no-draw
   function automatic type_code_type decode_type(input logic [FIELD_BITS-1:0] raw);
      type_code_type res;
      res.value = raw[TYPE_BITS-1:0];
      res.valid = !raw[FIELD_BITS-1] &&
                  (9'(raw[TYPE_BITS-1:0]) < 9'(TYPE_COUNT));
      return res;
   endfunction

   // equality of decoded types, all no-draw codes compare equal
   function automatic logic type_equal(input type_code_type a, input type_code_type b);
      return (a.valid == b.valid) && (!a.valid || (a.value == b.value));
   endfunction

endpackage

[rtl/core/tbm_lane.sv]
// tbm_lane: one neighbour lane, finds which neighbours share its type and
// whether it is a blend candidate
// depends on tbm_pkg
module tbm_lane
   import tbm_pkg::*;
(
   input  type_code_type   self_type,
   input  type_code_type   center_type,
   input  nb_vec_type      nb_types,
   output lane_result_type result
);

   logic [NEIGHBOURS-1:0] match;
   logic [COUNT_BITS-1:0] count;

   // compare against every neighbour and count the hits
   always_comb begin
      match = '0;
      count = '0;
      for (int j = 0; j < NEIGHBOURS; j++) begin
         match[j] = type_equal(self_type, nb_types[j]);
         count    = count + COUNT_BITS'(match[j]);
      end
   end

   // candidate only when strictly above a drawable centre
   assign result.cand  = self_type.valid && center_type.valid &&
                         (self_type.value > center_type.value);
   assign result.ty    = self_type.value;
   assign result.match = match;
   assign result.count = count;

endmodule

[rtl/core/tbm_merge.sv]
// tbm_merge: combines the lane reports into blend type, transition mask and skip flag
// depends on tbm_pkg
module tbm_merge
   import tbm_pkg::*;
(
   input  type_code_type    center_type,
   input  lane_vec_type     lanes,
   output merge_result_type result
);

   logic [COUNT_BITS-1:0] best_cnt;
   logic [NEIGHBOURS-1:0] win_match;
   logic [TYPE_BITS-1:0]  win_ty;
   logic [MASK_BITS-1:0]  mask;

   // highest count wins, strict compare keeps the earliest lane on ties
   always_comb begin
      best_cnt  = '0;
      win_match = '0;
      win_ty    = center_type.value;
      for (int i = 0; i < NEIGHBOURS; i++) begin
         if (lanes[i].cand && (lanes[i].count > best_cnt)) begin
            best_cnt  = lanes[i].count;
            win_match = lanes[i].match;
            win_ty    = lanes[i].ty;
         end
      end
   end

   // reorder the winner's hits from scan order into clockwise mask order
   always_comb begin
      mask = '0;
      for (int j = 0; j < NEIGHBOURS; j++) begin
         mask[SCAN_BIT[j]] = win_match[j];
      end
   end

   // no-draw centre gives an empty result
   always_comb begin
      if (!center_type.valid) begin
         result.skipped    = 1'b1;
         result.blend_type = '0;
         result.mask       = '0;
      end else begin
         result.skipped    = 1'b0;
         result.blend_type = win_ty;
         result.mask       = mask;
      end
   end

endmodule

[rtl/core/terrain_blend_type_and_mask_top.sv]
// terrain_blend_type_and_mask_top: 3x3 tile window to blend type and transition mask
// a transaction passes the lane stage register and then the output register before its rsp_strobe cycle
// throughput one transaction per cycle: eight lanes plus one merge stage, busy stays low
// synchronous active-high reset clears the valid pipeline, payload is not reset
// the receiver cannot stall, each result is shown for one cycle
// depends on tbm_pkg, tbm_lane, tbm_merge
module terrain_blend_type_and_mask_top
   import tbm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [FIELD_BITS-1:0] req_center_type,
   input  logic signed [FIELD_BITS-1:0] req_nw_type,
   input  logic signed [FIELD_BITS-1:0] req_n_type,
   input  logic signed [FIELD_BITS-1:0] req_ne_type,
   input  logic signed [FIELD_BITS-1:0] req_w_type,
   input  logic signed [FIELD_BITS-1:0] req_e_type,
   input  logic signed [FIELD_BITS-1:0] req_sw_type,
   input  logic signed [FIELD_BITS-1:0] req_s_type,
   input  logic signed [FIELD_BITS-1:0] req_se_type,
   output logic                        rsp_strobe,
   output logic                        rsp_skipped,
   output logic [TYPE_BITS-1:0]        rsp_blend_type,
   output logic [MASK_BITS-1:0]        rsp_transition_mask
);

   type_code_type    dec_center;
   nb_vec_type       dec_nb;
   lane_vec_type     lane_res;
   merge_result_type merge_res;
   logic             accept;

   logic             s1_valid_ff, s1_valid_in;
   type_code_type    s1_center_ff;
   lane_vec_type     s1_lane_ff;

   logic             rsp_strobe_ff, rsp_strobe_in;
   merge_result_type rsp_ff;

   // every cycle can take a transaction
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // decode the window, neighbours in scan order
   assign dec_center = decode_type(req_center_type);
   assign dec_nb[0]  = decode_type(req_nw_type);
   assign dec_nb[1]  = decode_type(req_n_type);
   assign dec_nb[2]  = decode_type(req_ne_type);
   assign dec_nb[3]  = decode_type(req_w_type);
   assign dec_nb[4]  = decode_type(req_e_type);
   assign dec_nb[5]  = decode_type(req_sw_type);
   assign dec_nb[6]  = decode_type(req_s_type);
   assign dec_nb[7]  = decode_type(req_se_type);

   // one lane per neighbour
   for (genvar i = 0; i < NEIGHBOURS; i++) begin : g_lane
      tbm_lane u_lane (
         .self_type   (dec_nb[i]),
         .center_type (dec_center),
         .nb_types    (dec_nb),
         .result      (lane_res[i])
      );
   end

   // lane stage register
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_center_ff <= dec_center;
      s1_lane_ff   <= lane_res;
   end

   // merge the lane reports
   tbm_merge u_merge (
      .center_type (s1_center_ff),
      .lanes       (s1_lane_ff),
      .result      (merge_res)
   );

   // output register
   assign rsp_strobe_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= merge_res;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_skipped         = rsp_ff.skipped;
   assign rsp_blend_type      = rsp_ff.blend_type;
   assign rsp_transition_mask = rsp_ff.mask;

   // each transaction yields one result, through the lane stage and output registers
   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("result missing two cycles after a transaction");

   a_no_stray_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result without a transaction");

   // skipped tiles carry an empty result
   a_skipped_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_skipped) |-> (rsp_blend_type == '0 && rsp_transition_mask == '0))
      else $error("skipped result with nonzero payload");

   // a nonzero mask means the blend type differs from the centre
   a_mask_needs_blend: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_skipped && rsp_transition_mask != '0) |->
      (rsp_blend_type != $past(req_center_type[TYPE_BITS-1:0], 2)))
      else $error("transition mask set with blend equal to centre");

endmodule

[tb/terrain_blend_type_and_mask_top_tb.sv]
// terrain_blend_type_and_mask_top_tb: self-checking bench for the 3x3 blend type and mask block
// predicts each result in the bench and compares it with the block's strobed outputs
// depends on tbm_pkg and terrain_blend_type_and_mask_top
`timescale 1ns / 1ps

module terrain_blend_type_and_mask_top_tb
   import tbm_pkg::*;
();

   localparam int STALL_LIMIT  = 400;
   localparam int RANDOM_WINS  = 900;
   localparam int SETTLE_TICKS = 8;

   // mask bit of each neighbour slot, slots in scan order NW, N, NE, W, E, SW, S, SE
   localparam logic [NEIGHBOURS-1:0][IDX_BITS-1:0] RING_BIT =
      {3'd4, 3'd5, 3'd6, 3'd3, 3'd7, 3'd2, 3'd1, 3'd0};

   // one tile window plus how the driver should present it
   typedef struct packed {
      logic [FIELD_BITS-1:0]                 center;
      logic [NEIGHBOURS-1:0][FIELD_BITS-1:0] nb;
      logic [3:0]                            gap;
      logic                                  drain;
   } tile_win_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [FIELD_BITS-1:0] req_center_type = '0;
   logic signed [FIELD_BITS-1:0] req_nw_type = '0;
   logic signed [FIELD_BITS-1:0] req_n_type  = '0;
   logic signed [FIELD_BITS-1:0] req_ne_type = '0;
   logic signed [FIELD_BITS-1:0] req_w_type  = '0;
   logic signed [FIELD_BITS-1:0] req_e_type  = '0;
   logic signed [FIELD_BITS-1:0] req_sw_type = '0;
   logic signed [FIELD_BITS-1:0] req_s_type  = '0;
   logic signed [FIELD_BITS-1:0] req_se_type = '0;
   logic                 rsp_strobe;
   logic                 rsp_skipped;
   logic [TYPE_BITS-1:0] rsp_blend_type;
   logic [MASK_BITS-1:0] rsp_transition_mask;

   tile_win_type     pending_wins[$];
   merge_result_type blend_expected[$];
   logic             took = 1'b0;
   int               idle_cnt = 0;
   int               errors = 0;
   int               stall_cnt = 0;
   bit               calm = 1'b0;
   bit               pause_next = 1'b0;

   terrain_blend_type_and_mask_top dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_center_type     (req_center_type),
      .req_nw_type         (req_nw_type),
      .req_n_type          (req_n_type),
      .req_ne_type         (req_ne_type),
      .req_w_type          (req_w_type),
      .req_e_type          (req_e_type),
      .req_sw_type         (req_sw_type),
      .req_s_type          (req_s_type),
      .req_se_type         (req_se_type),
      .rsp_strobe          (rsp_strobe),
      .rsp_skipped         (rsp_skipped),
      .rsp_blend_type      (rsp_blend_type),
      .rsp_transition_mask (rsp_transition_mask)
   );

   always #5 clock = ~clock;

   // material type of a raw field, -1 for no-draw
   function automatic int material_of(input logic [FIELD_BITS-1:0] raw);
      if (raw[FIELD_BITS-1])
         return -1;
      if (int'(raw[TYPE_BITS-1:0]) >= TYPE_COUNT)
         return -1;
      return int'(raw[TYPE_BITS-1:0]);
   endfunction

   // most frequent higher neighbour type and the ring of tiles that carry it
   function automatic merge_result_type blend_of(input tile_win_type w);
      merge_result_type r;
      int ctr;
      int ty[NEIGHBOURS];
      int pick;
      int best;
      int hits;
      r    = '0;
      ctr  = material_of(w.center);
      for (int i = 0; i < NEIGHBOURS; i++)
         ty[i] = material_of(w.nb[i]);
      if (ctr < 0) begin
         r.skipped = 1'b1;
         return r;
      end
      pick = ctr;
      best = 0;
      for (int i = 0; i < NEIGHBOURS; i++) begin
         if (ty[i] > ctr) begin
            hits = 0;
            for (int j = 0; j < NEIGHBOURS; j++)
               if (ty[j] == ty[i])
                  hits++;
            // strict compare keeps the earliest type in scan order on a tie
            if (hits > best) begin
               best = hits;
               pick = ty[i];
            end
         end
      end
      r.blend_type = pick[TYPE_BITS-1:0];
      if (pick != ctr)
         for (int i = 0; i < NEIGHBOURS; i++)
            if (ty[i] == pick)
               r.mask[RING_BIT[i]] = 1'b1;
      return r;
   endfunction

   // append one window, neighbours in scan order
   task automatic queue_win(input int c, input int a0, input int a1, input int a2, input int a3,
                            input int a4, input int a5, input int a6, input int a7);
      tile_win_type w;
      w.center = c[FIELD_BITS-1:0];
      w.nb[0]  = a0[FIELD_BITS-1:0];
      w.nb[1]  = a1[FIELD_BITS-1:0];
      w.nb[2]  = a2[FIELD_BITS-1:0];
      w.nb[3]  = a3[FIELD_BITS-1:0];
      w.nb[4]  = a4[FIELD_BITS-1:0];
      w.nb[5]  = a5[FIELD_BITS-1:0];
      w.nb[6]  = a6[FIELD_BITS-1:0];
      w.nb[7]  = a7[FIELD_BITS-1:0];
      w.gap    = calm ? 4'd0 : 4'($urandom_range(0, 10));
      w.drain  = pause_next;
      pause_next = 1'b0;
      pending_wins = {pending_wins, w};
   endtask

   // put one window on the request ports
   task automatic drive_win(input tile_win_type w);
      start           <= 1'b1;
      req_center_type <= w.center;
      req_nw_type     <= w.nb[0];
      req_n_type      <= w.nb[1];
      req_ne_type     <= w.nb[2];
      req_w_type      <= w.nb[3];
      req_e_type      <= w.nb[4];
      req_sw_type     <= w.nb[5];
      req_s_type      <= w.nb[6];
      req_se_type     <= w.nb[7];
   endtask

   // driver: moves on at the falling edge after an accepted transaction
   always @(negedge clock) begin
      if (!reset) begin
         if (start && took) begin
            if (pending_wins.size() != 0 && pending_wins[0].gap == 0 && !pending_wins[0].drain)
               drive_win(pending_wins.pop_front());
            else begin
               start    <= 1'b0;
               idle_cnt <= 0;
            end
         end else if (!start && pending_wins.size() != 0) begin
            if (idle_cnt < int'(pending_wins[0].gap))
               idle_cnt <= idle_cnt + 1;
            else if (!pending_wins[0].drain || blend_expected.size() == 0) begin
               drive_win(pending_wins.pop_front());
               idle_cnt <= 0;
            end
         end
      end
   end

   // monitor: checks strobed results, then records the transaction taken at this edge
   always @(posedge clock) begin
      merge_result_type exp_r;
      merge_result_type pred_r;
      if (rsp_strobe && !reset) begin
         if (blend_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result skipped=%b blend=%0d mask=%b", $time,
                     rsp_skipped, rsp_blend_type, rsp_transition_mask);
         end else begin
            exp_r = blend_expected.pop_front();
            if (rsp_skipped !== exp_r.skipped) begin
               errors++;
               $display("%0t: skipped expected %b actual %b", $time, exp_r.skipped,
                        rsp_skipped);
            end
            if (rsp_blend_type !== exp_r.blend_type) begin
               errors++;
               $display("%0t: blend_type expected %0d actual %0d", $time, exp_r.blend_type,
                        rsp_blend_type);
            end
            if (rsp_transition_mask !== exp_r.mask) begin
               errors++;
               $display("%0t: transition_mask expected %b actual %b", $time, exp_r.mask,
                        rsp_transition_mask);
            end
         end
      end
      took <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         pred_r = blend_of({req_center_type, req_se_type, req_s_type,
                            req_sw_type, req_e_type, req_w_type, req_ne_type,
                            req_n_type, req_nw_type, 4'd0, 1'b0});
         blend_expected = {blend_expected, pred_r};
      end
   end

   // watchdog on cycles with no transaction and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cnt <= 0;
      else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int c;
      int t;
      int kind;
      int pal[3];
      int v[NEIGHBOURS];

      // directed windows
      calm = 1'b1;
      queue_win(-1, -1, -1, -1, -1, -1, -1, -1, -1);
      queue_win(-64, 63, 63, 63, 63, 63, 63, 63, 63);
      queue_win(-2, 5, 5, 5, 5, 5, 5, 5, 5);
      queue_win(63, -1, -1, -1, -1, -1, -1, -1, -1);
      queue_win(63, 0, 62, -64, 63, 1, -1, 10, 63);
      queue_win(0, 63, 63, 63, 63, 63, 63, 63, 63);
      queue_win(0, 0, 0, 0, 0, 0, 0, 0, 0);
      queue_win(0, -64, -64, -64, -64, -64, -64, -64, -64);
      queue_win(20, 3, 19, 20, 0, -1, 20, 7, 1);
      // tie between two types, the one seen first in scan order wins
      queue_win(4, 9, 7, 7, 9, 1, -1, 2, 0);
      queue_win(4, 7, 9, 9, 7, 1, -1, 2, 0);
      // tie of single higher neighbours at the far end of the scan
      queue_win(30, 1, 1, 1, 1, 1, 1, 40, 35);
      // later type more frequent than the first one seen
      queue_win(10, 11, 12, 12, 12, 11, 0, -1, 12);
      // one higher neighbour in each position in turn
      queue_win(5, 6, 0, 0, 0, 0, 0, 0, 0);
      queue_win(5, 0, 6, 0, 0, 0, 0, 0, 0);
      queue_win(5, 0, 0, 6, 0, 0, 0, 0, 0);
      queue_win(5, 0, 0, 0, 6, 0, 0, 0, 0);
      queue_win(5, 0, 0, 0, 0, 6, 0, 0, 0);
      queue_win(5, 0, 0, 0, 0, 0, 6, 0, 0);
      queue_win(5, 0, 0, 0, 0, 0, 0, 6, 0);
      queue_win(5, 0, 0, 0, 0, 0, 0, 0, 6);
      // three-way tie of pairs
      queue_win(1, 50, 40, 30, 30, 40, 50, -1, 0);

      // random windows, mostly built from a small palette around the centre
      for (int n = 0; n < RANDOM_WINS; n++) begin
         if (n % 60 == 0)
            calm = ($urandom_range(0, 2) == 0);
         if (n % 250 == 0)
            pause_next = 1'b1;
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            c = $urandom_range(0, 62);
            for (int k = 0; k < 3; k++) begin
               t = $urandom_range(0, 3);
               if (t < 2)
                  pal[k] = $urandom_range(c + 1, 63);
               else if (t == 2)
                  pal[k] = $urandom_range(0, c);
               else
                  pal[k] = -1;
            end
            for (int k = 0; k < NEIGHBOURS; k++)
               v[k] = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127)
                                                    : pal[$urandom_range(0, 2)];
         end else begin
            if (kind == 7) begin
               t = $urandom_range(1, 64);
               c = -t;
            end else
               c = $urandom_range(0, 127);
            for (int k = 0; k < NEIGHBOURS; k++)
               v[k] = $urandom_range(0, 127);
         end
         queue_win(c, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
      end

      // reset, released on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every transaction to be sent and answered
      while (pending_wins.size() != 0 || start || blend_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
rtl/core/tbm_pkg.sv
rtl/core/tbm_lane.sv
rtl/core/tbm_merge.sv
rtl/core/terrain_blend_type_and_mask_top.sv
tb/terrain_blend_type_and_mask_top_tb.sv
